@@ hdl/cfp_pkg.sv @@
`default_nettype none
package cfp_pkg;

  localparam logic [7:0]  MIN_LEN       = 8'd3;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [7:0]  HEAD_RESET    = 8'd170;
  localparam logic [7:0]  TAIL_RESET    = 8'd85;
  localparam logic [15:0] TIMEOUT_RESET = 16'd300;

  localparam logic [1:0] REG_HEAD    = 2'd0;
  localparam logic [1:0] REG_TAIL    = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [2:0] {
    PH_HEAD, PH_LEN, PH_CMD, PH_VER, PH_DATA, PH_CRCH, PH_CRCL, PH_TAIL
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_ACCEPT  = 2'd1,
    KIND_DROP    = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    CAUSE_NONE    = 3'd0,
    CAUSE_BAD_LEN = 3'd1,
    CAUSE_CRC     = 3'd2,
    CAUSE_TAIL    = 3'd3,
    CAUSE_TIMEOUT = 3'd4
  } cause_t;

  typedef struct packed {
    logic [7:0]  head_byte;
    logic [7:0]  tail_byte;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] command_code;
    logic [7:0] version_code;
    logic [7:0] payload_length;
    cause_t     drop_cause;
  } res_t;

  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ hdl/crc_framed_command_parser.sv @@
// channel  direction  handshake          payload
// in_      input      in_valid/in_stall  op, rx_byte
// out_     output     out_valid/out_stall kind, payload/frame fields, drop_cause
// cfg_     input      cfg_we             cfg_index, cfg_data
//
// One request per cycle while the result side is not stalled; a taken request is held in
// the input register, then the CRC byte update and phase step load the result register.
// Synchronous active-low reset: parser idle, waiting for head, registers at defaults.
// A stalled result holds; the input register keeps taking requests while the
// result register is free or being taken.
`default_nettype none
module crc_framed_command_parser
  import cfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_op,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_payload_byte,
  output logic [7:0]       out_payload_index,
  output logic [7:0]       out_command_code,
  output logic [7:0]       out_version_code,
  output logic [7:0]       out_payload_length,
  output logic [2:0]       out_drop_cause,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cfg_t cfg;
  res_t res;
  res_t res_r;

  logic       s1_v_r;
  logic       s1_op_r;
  logic [7:0] s1_byte_r;
  logic       out_free;
  logic       step_en;
  logic       in_take;

  assign out_free = !res_r.valid || !out_stall;
  assign step_en  = s1_v_r && out_free;
  assign in_stall = s1_v_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  cfp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cfp_parser_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .op      (s1_op_r),
    .rx_byte (s1_byte_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (!in_stall) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r   <= in_op;
      s1_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.valid <= 1'b0;
    end else if (out_free) begin
      res_r.valid <= step_en && res.valid;
    end
    if (step_en && res.valid) begin
      res_r.kind           <= res.kind;
      res_r.payload_byte   <= res.payload_byte;
      res_r.payload_index  <= res.payload_index;
      res_r.command_code   <= res.command_code;
      res_r.version_code   <= res.version_code;
      res_r.payload_length <= res.payload_length;
      res_r.drop_cause     <= res.drop_cause;
    end
  end

  assign out_valid          = res_r.valid;
  assign out_kind           = res_r.kind;
  assign out_payload_byte   = res_r.payload_byte;
  assign out_payload_index  = res_r.payload_index;
  assign out_command_code   = res_r.command_code;
  assign out_version_code   = res_r.version_code;
  assign out_payload_length = res_r.payload_length;
  assign out_drop_cause     = res_r.drop_cause;

`ifndef SYNTHESIS
  a_drop_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_DROP) |->
      (out_drop_cause == CAUSE_BAD_LEN || out_drop_cause == CAUSE_CRC ||
       out_drop_cause == CAUSE_TAIL || out_drop_cause == CAUSE_TIMEOUT))
    else $error("drop without cause");

  a_accept_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_ACCEPT) |->
      (out_drop_cause == CAUSE_NONE && out_payload_byte == 8'd0 &&
       out_payload_index == 8'd0))
    else $error("accept carries stray fields");

  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_PAYLOAD) |->
      (out_drop_cause == CAUSE_NONE && out_payload_length == 8'd0 &&
       out_command_code == 8'd0))
    else $error("payload carries stray fields");

  a_step_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> s1_v_r)
    else $error("input register lost a request");
`endif

endmodule
`default_nettype wire

@@ hdl/cfp_cfg_regs.sv @@
`default_nettype none
module cfp_cfg_regs
  import cfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output cfg_t             cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_HEAD:    cfg_nxt.head_byte     = cfg_data[7:0];
        REG_TAIL:    cfg_nxt.tail_byte     = cfg_data[7:0];
        REG_TIMEOUT: cfg_nxt.timeout_ticks = cfg_data;
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.head_byte     <= HEAD_RESET;
      cfg_r.tail_byte     <= TAIL_RESET;
      cfg_r.timeout_ticks <= TIMEOUT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

@@ hdl/cfp_parser_core.sv @@
`default_nettype none
module cfp_parser_core
  import cfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_en,
  input  wire logic       op,
  input  wire logic [7:0] rx_byte,
  input  wire cfg_t       cfg,
  output res_t            res
);

  phase_t      phase_r,    phase_nxt;
  logic [7:0]  length_r,   length_nxt;
  logic [7:0]  left_r,     left_nxt;
  logic [7:0]  index_r,    index_nxt;
  logic [7:0]  cmd_r,      cmd_nxt;
  logic [7:0]  ver_r,      ver_nxt;
  logic [15:0] crc_r,      crc_nxt;
  logic [15:0] idle_r,     idle_nxt;
  logic        timer_on_r, timer_on_nxt;

  logic [15:0] crc_upd;
  logic [15:0] idle_inc;
  logic [7:0]  left_dec;

  assign crc_upd  = crc_add((phase_r == PH_HEAD) ? CRC_INIT : crc_r, rx_byte);
  assign idle_inc = idle_r + 16'd1;
  assign left_dec = left_r - 8'd1;

  always_comb begin
    phase_nxt    = phase_r;
    length_nxt   = length_r;
    left_nxt     = left_r;
    index_nxt    = index_r;
    cmd_nxt      = cmd_r;
    ver_nxt      = ver_r;
    crc_nxt      = crc_r;
    idle_nxt     = idle_r;
    timer_on_nxt = timer_on_r;
    res          = '0;
    res.kind     = KIND_PAYLOAD;
    res.drop_cause = CAUSE_NONE;

    if (op == OP_TICK) begin
      if (timer_on_r) begin
        idle_nxt = idle_inc;
        if (idle_inc >= cfg.timeout_ticks) begin
          idle_nxt     = '0;
          timer_on_nxt = 1'b0;
          if (phase_r != PH_HEAD) begin
            phase_nxt      = PH_HEAD;
            res.valid      = 1'b1;
            res.kind       = KIND_DROP;
            res.drop_cause = CAUSE_TIMEOUT;
          end
        end
      end
    end else begin
      timer_on_nxt = 1'b1;
      idle_nxt     = '0;
      unique case (phase_r)
        PH_HEAD: begin
          length_nxt = '0;
          index_nxt  = '0;
          left_nxt   = '0;
          if (rx_byte == cfg.head_byte) begin
            crc_nxt   = crc_upd;
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          if (rx_byte < MIN_LEN) begin
            phase_nxt      = PH_HEAD;
            res.valid      = 1'b1;
            res.kind       = KIND_DROP;
            res.drop_cause = CAUSE_BAD_LEN;
          end else begin
            length_nxt = rx_byte;
            left_nxt   = rx_byte - MIN_LEN;
            crc_nxt    = crc_upd;
            phase_nxt  = PH_CMD;
          end
        end
        PH_CMD: begin
          cmd_nxt   = rx_byte;
          crc_nxt   = crc_upd;
          phase_nxt = PH_VER;
        end
        PH_VER: begin
          ver_nxt   = rx_byte;
          crc_nxt   = crc_upd;
          phase_nxt = (left_r == 8'd0) ? PH_CRCH : PH_DATA;
        end
        PH_DATA: begin
          res.valid         = 1'b1;
          res.kind          = KIND_PAYLOAD;
          res.payload_byte  = rx_byte;
          res.payload_index = index_r;
          index_nxt         = index_r + 8'd1;
          crc_nxt           = crc_upd;
          left_nxt          = left_dec;
          if (left_dec == 8'd0) begin
            phase_nxt = PH_CRCH;
          end
        end
        PH_CRCH: begin
          if (rx_byte != crc_r[15:8]) begin
            phase_nxt      = PH_HEAD;
            res.valid      = 1'b1;
            res.kind       = KIND_DROP;
            res.drop_cause = CAUSE_CRC;
          end else begin
            phase_nxt = PH_CRCL;
          end
        end
        PH_CRCL: begin
          if (rx_byte != crc_r[7:0]) begin
            phase_nxt      = PH_HEAD;
            res.valid      = 1'b1;
            res.kind       = KIND_DROP;
            res.drop_cause = CAUSE_CRC;
          end else begin
            phase_nxt = PH_TAIL;
          end
        end
        PH_TAIL: begin
          phase_nxt = PH_HEAD;
          res.valid = 1'b1;
          if (rx_byte != cfg.tail_byte) begin
            res.kind       = KIND_DROP;
            res.drop_cause = CAUSE_TAIL;
          end else begin
            timer_on_nxt       = 1'b0;
            res.kind           = KIND_ACCEPT;
            res.command_code   = cmd_r;
            res.version_code   = ver_r;
            res.payload_length = length_r - MIN_LEN;
          end
        end
        default: phase_nxt = PH_HEAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEAD;
      length_r   <= '0;
      left_r     <= '0;
      index_r    <= '0;
      cmd_r      <= '0;
      ver_r      <= '0;
      crc_r      <= CRC_INIT;
      idle_r     <= '0;
      timer_on_r <= 1'b0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      length_r   <= length_nxt;
      left_r     <= left_nxt;
      index_r    <= index_nxt;
      cmd_r      <= cmd_nxt;
      ver_r      <= ver_nxt;
      crc_r      <= crc_nxt;
      idle_r     <= idle_nxt;
      timer_on_r <= timer_on_nxt;
    end
  end

endmodule
`default_nettype wire

@@ bench/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cfp_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_CYCLES = 8;

  typedef enum int {
    FAULT_NONE, FAULT_LEN, FAULT_CRC_HI, FAULT_CRC_LO, FAULT_TAIL, FAULT_CUT
  } frame_fault_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] byte_val;
    logic [7:0] pos;
    logic [7:0] cmd;
    logic [7:0] ver;
    logic [7:0] plen;
    cause_t     cause;
  } parser_event_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_op = OP_BYTE;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_payload_byte;
  logic [7:0]  out_payload_index;
  logic [7:0]  out_command_code;
  logic [7:0]  out_version_code;
  logic [7:0]  out_payload_length;
  logic [2:0]  out_drop_cause;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_HEAD;
  logic [15:0] cfg_data = 16'h0000;

  // mirror of the parser and its registers
  phase_t      p_phase = PH_HEAD;
  logic [7:0]  p_len = 8'h00;
  logic [7:0]  p_left = 8'h00;
  logic [7:0]  p_next = 8'h00;
  logic [7:0]  p_cmd = 8'h00;
  logic [7:0]  p_ver = 8'h00;
  logic [15:0] p_crc = CRC_INIT;
  logic [15:0] p_idle = 16'h0000;
  logic        p_timer_on = 1'b0;
  logic [7:0]  set_head = HEAD_RESET;
  logic [7:0]  set_tail = TAIL_RESET;
  logic [15:0] set_timeout = TIMEOUT_RESET;

  parser_event_t pending_events[$];
  int sent_count = 0;
  int error_count = 0;
  int cycle_count = 0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int hold_off_cycles = 0;
  int rx_burst = 0;

  crc_framed_command_parser DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_payload_byte(out_payload_byte), .out_payload_index(out_payload_index),
    .out_command_code(out_command_code), .out_version_code(out_version_code),
    .out_payload_length(out_payload_length), .out_drop_cause(out_drop_cause),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [15:0] modbus_crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ data[k]) c = (c >> 1) ^ CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

  function automatic bit frame_parser_step(input logic op, input logic [7:0] b,
                                           output parser_event_t ev);
    ev = '0;
    if (op == OP_TICK) begin
      if (!p_timer_on) return 1'b0;
      p_idle = p_idle + 16'd1;
      if (p_idle >= set_timeout) begin
        p_idle = 16'd0;
        p_timer_on = 1'b0;
        if (p_phase != PH_HEAD) begin
          ev.kind = KIND_DROP;
          ev.cause = CAUSE_TIMEOUT;
          p_phase = PH_HEAD;
          return 1'b1;
        end
      end
      return 1'b0;
    end
    p_timer_on = 1'b1;
    p_idle = 16'd0;
    case (p_phase)
      PH_HEAD: begin
        p_len = 8'd0;
        p_next = 8'd0;
        p_left = 8'd0;
        if (b == set_head) begin
          p_crc = modbus_crc_byte(CRC_INIT, b);
          p_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        if (b < MIN_LEN) begin
          ev.kind = KIND_DROP;
          ev.cause = CAUSE_BAD_LEN;
          p_phase = PH_HEAD;
          return 1'b1;
        end
        p_len = b;
        p_left = b - MIN_LEN;
        p_crc = modbus_crc_byte(p_crc, b);
        p_phase = PH_CMD;
      end
      PH_CMD: begin
        p_cmd = b;
        p_crc = modbus_crc_byte(p_crc, b);
        p_phase = PH_VER;
      end
      PH_VER: begin
        p_ver = b;
        p_crc = modbus_crc_byte(p_crc, b);
        if (p_left == 8'd0) p_phase = PH_CRCH;
        else p_phase = PH_DATA;
      end
      PH_DATA: begin
        ev.kind = KIND_PAYLOAD;
        ev.byte_val = b;
        ev.pos = p_next;
        p_next = p_next + 8'd1;
        p_crc = modbus_crc_byte(p_crc, b);
        p_left = p_left - 8'd1;
        if (p_left == 8'd0) p_phase = PH_CRCH;
        return 1'b1;
      end
      PH_CRCH: begin
        if (b != p_crc[15:8]) begin
          ev.kind = KIND_DROP;
          ev.cause = CAUSE_CRC;
          p_phase = PH_HEAD;
          return 1'b1;
        end
        p_phase = PH_CRCL;
      end
      PH_CRCL: begin
        if (b != p_crc[7:0]) begin
          ev.kind = KIND_DROP;
          ev.cause = CAUSE_CRC;
          p_phase = PH_HEAD;
          return 1'b1;
        end
        p_phase = PH_TAIL;
      end
      default: begin
        if (b != set_tail) begin
          ev.kind = KIND_DROP;
          ev.cause = CAUSE_TAIL;
          p_phase = PH_HEAD;
          return 1'b1;
        end
        p_timer_on = 1'b0;
        p_phase = PH_HEAD;
        ev.kind = KIND_ACCEPT;
        ev.cmd = p_cmd;
        ev.ver = p_ver;
        ev.plen = p_len - MIN_LEN;
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic string describe(input parser_event_t e);
    return $sformatf("kind=%0d byte=%02h idx=%0d cmd=%02h ver=%02h len=%0d cause=%0d",
                     e.kind, e.byte_val, e.pos, e.cmd, e.ver, e.plen, e.cause);
  endfunction

  always @(posedge clk) begin : frame_monitor
    parser_event_t ev;
    parser_event_t got;
    parser_event_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        if (frame_parser_step(in_op, in_rx_byte, ev)) pending_events.push_back(ev);
      end
      if (out_valid && !out_stall) begin
        got.kind = kind_t'(out_kind);
        got.byte_val = out_payload_byte;
        got.pos = out_payload_index;
        got.cmd = out_command_code;
        got.ver = out_version_code;
        got.plen = out_payload_length;
        got.cause = cause_t'(out_drop_cause);
        if (pending_events.size() == 0) begin
          error_count++;
          if (error_count <= 10) $display("unexpected result: %s", describe(got));
        end else begin
          want = pending_events.pop_front();
          if (got.kind !== want.kind || got.byte_val !== want.byte_val ||
              got.pos !== want.pos || got.cmd !== want.cmd || got.ver !== want.ver ||
              got.plen !== want.plen || got.cause !== want.cause) begin
            error_count++;
            if (error_count <= 10)
              $display("result mismatch: expected %s, got %s", describe(want), describe(got));
          end
        end
      end
    end
  end

  // receiver: random stall bursts, plus a long hold-off when asked
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles--;
      out_stall <= 1'b1;
    end else if (rx_burst > 0) begin
      rx_burst--;
      out_stall <= 1'b1;
    end else if (rx_idle_on && $urandom_range(0, 11) == 0) begin
      rx_burst = $urandom_range(0, 16);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("crc_framed_command_parser regression: fail");
    $finish;
  end

  task automatic send_request(input logic op, input logic [7:0] b);
    int gap;
    if (tx_idle_on && $urandom_range(0, 11) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  task automatic settle;
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_HEAD:    set_head = data[7:0];
      REG_TAIL:    set_tail = data[7:0];
      REG_TIMEOUT: set_timeout = data;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] head, input logic [7:0] tail,
                            input logic [15:0] limit);
    settle();
    write_reg(REG_HEAD, {8'($urandom), head});
    write_reg(REG_TAIL, {8'($urandom), tail});
    write_reg(REG_TIMEOUT, limit);
    cfg_we <= 1'b0;
  endtask

  function automatic int payload_len_pick();
    if ($urandom_range(0, 39) == 0) return $urandom_range(9, 252);
    return $urandom_range(0, 8);
  endfunction

  task automatic send_frame(input frame_fault_t fault, input int plen, input int tick_odds);
    logic [7:0]  seq[$];
    logic [15:0] crc;
    int cut;
    seq.push_back(set_head);
    if (fault == FAULT_LEN) begin
      seq.push_back(8'($urandom_range(0, MIN_LEN - 1)));
    end else begin
      seq.push_back(8'(plen) + MIN_LEN);
      seq.push_back(8'($urandom));
      seq.push_back(8'($urandom));
      repeat (plen) seq.push_back(8'($urandom));
      crc = CRC_INIT;
      foreach (seq[i]) crc = modbus_crc_byte(crc, seq[i]);
      seq.push_back(crc[15:8] ^ ((fault == FAULT_CRC_HI) ? 8'($urandom_range(1, 255)) : 8'h00));
      seq.push_back(crc[7:0] ^ ((fault == FAULT_CRC_LO) ? 8'($urandom_range(1, 255)) : 8'h00));
      seq.push_back(set_tail ^ ((fault == FAULT_TAIL) ? 8'($urandom_range(1, 255)) : 8'h00));
      if (fault == FAULT_CUT) begin
        cut = $urandom_range(1, seq.size() - 1);
        while (seq.size() > cut) void'(seq.pop_back());
      end
    end
    foreach (seq[i]) begin
      if (tick_odds != 0 && $urandom_range(1, tick_odds) == 1)
        repeat ($urandom_range(1, 3)) send_request(OP_TICK, 8'($urandom));
      send_request(OP_BYTE, seq[i]);
    end
  endtask

  task automatic send_mixed_traffic(input int quota);
    int stop_at;
    int pick;
    stop_at = sent_count + quota;
    while (sent_count < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_frame(FAULT_NONE, payload_len_pick(), 16);
      end else if (pick < 85) begin
        send_frame(frame_fault_t'($urandom_range(FAULT_LEN, FAULT_CUT)), payload_len_pick(), 16);
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 4)) send_request(OP_BYTE, 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 8)) send_request(OP_TICK, 8'($urandom));
      end
    end
  endtask

  // reset values of the registers, the length, CRC and tail drop causes, idle ticks and stray bytes
  task automatic test_reset_values;
    send_request(OP_TICK, 8'hFF);
    send_request(OP_BYTE, TAIL_RESET);
    send_frame(FAULT_NONE, 0, 0);
    send_frame(FAULT_LEN, 0, 0);
    send_frame(FAULT_LEN, 0, 0);
    send_frame(FAULT_CRC_HI, 0, 0);
    send_frame(FAULT_CRC_LO, 1, 0);
    send_frame(FAULT_TAIL, 2, 0);
  endtask

  task automatic test_register_extremes;
    set_config(8'h00, 8'hFF, 16'd1);
    // bad length byte equal to the head value is not taken as a new head
    send_request(OP_BYTE, 8'h00);
    send_request(OP_BYTE, 8'h00);
    send_frame(FAULT_NONE, 3, 0);
    send_frame(FAULT_NONE, 2, 0);
    send_request(OP_BYTE, set_head);
    send_request(OP_BYTE, 8'd9);
    send_request(OP_TICK, 8'hFF);
    // stray byte arms the timer while idle: expiry is silent
    send_request(OP_BYTE, 8'h42);
    send_request(OP_TICK, 8'h00);

    set_config(8'hFF, 8'h00, 16'd0);
    send_request(OP_BYTE, set_head);
    send_request(OP_TICK, 8'h00);
    send_frame(FAULT_NONE, 252, 0);

    set_config(8'h3C, 8'hC3, 16'hFFFF);
    tx_idle_on = 1'b0;
    send_request(OP_BYTE, set_head);
    send_request(OP_BYTE, 8'd8);
    send_request(OP_BYTE, 8'h11);
    send_request(OP_BYTE, 8'h22);
    repeat (40) send_request(OP_TICK, 8'h00);
    send_request(OP_BYTE, 8'hA5);
    repeat (40) send_request(OP_TICK, 8'hFF);
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_settings;
    logic [7:0] head;
    logic [15:0] limit;
    repeat (4) begin
      head = 8'($urandom);
      limit = ($urandom_range(0, 3) == 0) ? TIMEOUT_RESET : 16'($urandom_range(1, 6));
      set_config(head, ($urandom_range(0, 3) == 0) ? head : 8'($urandom), limit);
      send_mixed_traffic(230);
    end
  endtask

  // receiver holds off while frames keep coming, so the input side backs up
  task automatic test_backpressure;
    set_config(8'($urandom), 8'($urandom), 16'd5);
    hold_off_cycles = 300;
    send_frame(FAULT_NONE, 40, 0);
    send_frame(FAULT_NONE, 40, 0);
    send_mixed_traffic(60);
  endtask

  task automatic test_steady_stream;
    set_config(HEAD_RESET, TAIL_RESET, 16'd3);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_mixed_traffic(400);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_register_extremes();
    test_random_settings();
    test_backpressure();
    test_steady_stream();
    settle();
    if (error_count == 0 && pending_events.size() == 0) begin
      $display("crc_framed_command_parser regression: pass");
    end else begin
      $display("crc_framed_command_parser regression: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/cfp_pkg.sv
hdl/cfp_cfg_regs.sv
hdl/cfp_parser_core.sv
hdl/crc_framed_command_parser.sv
bench/tb.sv
